### sv/gppr_pkg.sv
`timescale 1ns / 1ps

package gppr_pkg;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_HORIZON = 2'd1,
      STATUS_BEHIND  = 2'd2,
      STATUS_SAT     = 2'd3
   } status_type;

   localparam logic [2:0] REG_LIFT_X     = 3'd0;
   localparam logic [2:0] REG_LIFT_Y     = 3'd1;
   localparam logic [2:0] REG_LIFT_Z     = 3'd2;
   localparam logic [2:0] REG_MOUNT      = 3'd3;
   localparam logic [2:0] REG_COL0       = 3'd4;
   localparam logic [2:0] REG_COL1       = 3'd5;
   localparam logic [2:0] REG_SHIFT      = 3'd6;
   localparam logic [2:0] REG_INTRINSICS = 3'd7;

   localparam int COEF_W  = 21;
   localparam int TRIP_W  = 63;
   localparam int OUT_W   = 24;
   localparam int OUT_MAX = 8388607;
   localparam int OUT_MIN = -8388608;

   // 0.01 m in Q.32
   localparam int DEPTH_MIN_Q32 = 42949673;
   localparam int HORIZON_RATIO = 9999;
   localparam int NORM_W        = 24;

   // ground quotient stays below 100 * 2^20 for an accepted ray
   localparam int GQ_W    = 27;
   localparam int GROUND_W = GQ_W + 2;
   localparam int CAM_W   = 52;
   localparam int Q18_SH  = 14;
   localparam int MAG18_W = CAM_W - Q18_SH - 1;
   // quotients at or above 2^PQ_W saturate whatever the center adds
   localparam int PQ_W    = 25;
   localparam int SUM_W   = PQ_W + 2;

   function automatic logic signed [COEF_W-1:0] field21(input logic [TRIP_W-1:0] word,
                                                        input logic [1:0] idx);
      return signed'(word[COEF_W*idx +: COEF_W]);
   endfunction

endpackage

### sv/gppr_div.sv
`timescale 1ns / 1ps

module gppr_div #(
   parameter int NUM_W  = 55,
   parameter int DEN_W  = 35,
   parameter int QUO_W  = 27,
   parameter int SIDE_W = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num0,
   input  logic [NUM_W-1:0]  in_num1,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo0,
   output logic [QUO_W-1:0]  out_quo1,
   output logic              out_ovf0,
   output logic              out_ovf1,
   output logic [SIDE_W-1:0] out_side
);

   localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   logic              valid_ff [QUO_W];
   logic [NUM_W-1:0]  rem0_ff  [QUO_W];
   logic [NUM_W-1:0]  rem1_ff  [QUO_W];
   logic [DEN_W-1:0]  den_ff   [QUO_W];
   logic [QUO_W-1:0]  quo0_ff  [QUO_W];
   logic [QUO_W-1:0]  quo1_ff  [QUO_W];
   logic [SIDE_W-1:0] side_ff  [QUO_W];

   // restoring division, one quotient bit per stage, MSB first
   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      logic              v_prev;
      logic [NUM_W-1:0]  r0_prev;
      logic [NUM_W-1:0]  r1_prev;
      logic [DEN_W-1:0]  d_prev;
      logic [QUO_W-1:0]  q0_prev;
      logic [QUO_W-1:0]  q1_prev;
      logic [SIDE_W-1:0] sd_prev;
      logic [CMP_W-1:0]  dsh;
      logic              ge0;
      logic              ge1;
      logic [NUM_W-1:0]  rem0_in;
      logic [NUM_W-1:0]  rem1_in;

      if (k == 0) begin : g_head
         assign v_prev  = in_valid;
         assign r0_prev = in_num0;
         assign r1_prev = in_num1;
         assign d_prev  = in_den;
         assign q0_prev = '0;
         assign q1_prev = '0;
         assign sd_prev = in_side;
      end else begin : g_body
         assign v_prev  = valid_ff[k-1];
         assign r0_prev = rem0_ff[k-1];
         assign r1_prev = rem1_ff[k-1];
         assign d_prev  = den_ff[k-1];
         assign q0_prev = quo0_ff[k-1];
         assign q1_prev = quo1_ff[k-1];
         assign sd_prev = side_ff[k-1];
      end

      assign dsh     = CMP_W'(d_prev) << (QUO_W - 1 - k);
      assign ge0     = CMP_W'(r0_prev) >= dsh;
      assign ge1     = CMP_W'(r1_prev) >= dsh;
      assign rem0_in = ge0 ? NUM_W'(CMP_W'(r0_prev) - dsh) : r0_prev;
      assign rem1_in = ge1 ? NUM_W'(CMP_W'(r1_prev) - dsh) : r1_prev;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem0_ff[k] <= rem0_in;
            rem1_ff[k] <= rem1_in;
            den_ff[k]  <= d_prev;
            quo0_ff[k] <= {q0_prev[QUO_W-2:0], ge0};
            quo1_ff[k] <= {q1_prev[QUO_W-2:0], ge1};
            side_ff[k] <= sd_prev;
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quo0  = quo0_ff[QUO_W-1];
   assign out_quo1  = quo1_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];
   // a remainder left at or above the divisor means the quotient did not fit
   assign out_ovf0  = CMP_W'(rem0_ff[QUO_W-1]) >= CMP_W'(den_ff[QUO_W-1]);
   assign out_ovf1  = CMP_W'(rem1_ff[QUO_W-1]) >= CMP_W'(den_ff[QUO_W-1]);

endmodule

### sv/ground_plane_pixel_reprojection.sv
`timescale 1ns / 1ps

// Reprojects one pixel per clock through the ground plane into the earlier camera
// image. The pipeline accepts a new transaction every cycle and returns one result
// per transaction, in order. In the pipeline, 7 stages lift the pixel to a ray and
// run the horizon test, 27 stages divide for the ground intersection (one quotient
// bit per stage), 5 stages apply the motion and depth test, 25 stages divide for
// the perspective projection, and one output register. Any stall on the result
// side holds the whole pipeline and drops req_ready. Status: 0 valid, 1 ray not
// below the horizon, 2 behind the camera, 3 clamped. Coordinates are zero when
// status is 1 or 2. Registers must only be written while no transaction is in
// flight.

module ground_plane_pixel_reprojection
   import gppr_pkg::*;
#(
   parameter int PIXEL_BITS    = 12,
   parameter int OUT_FRAC_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [PIXEL_BITS-1:0]   req_pixel_x,
   input  logic [PIXEL_BITS-1:0]   req_pixel_y,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_status,
   output logic signed [OUT_W-1:0] rsp_proj_x,
   output logic signed [OUT_W-1:0] rsp_proj_y,
   input  logic                    csr_write_en,
   input  logic [2:0]              csr_index,
   input  logic [63:0]             csr_wdata
);

   localparam int PROD_W   = PIXEL_BITS + COEF_W + 1;
   localparam int RAY_W    = PIXEL_BITS + 23;
   localparam int NUMS_W   = RAY_W + COEF_W;
   localparam int NUMG_W   = RAY_W + 20;
   localparam int SH_W     = $clog2(RAY_W - NORM_W + 1);
   localparam int SQ_W     = 2 * NORM_W;
   localparam int LIM_W    = SQ_W + 14;
   localparam int GPROD_W  = COEF_W + GROUND_W;
   localparam int SCALE_SH = OUT_FRAC_BITS - 4;
   localparam int NUMP_W   = 16 + MAG18_W + SCALE_SH;

   typedef struct packed {
      logic [NUMG_W-1:0] num0;
      logic [NUMG_W-1:0] num1;
      logic [RAY_W-1:0]  den;
      logic              sgn0;
      logic              sgn1;
   } gdiv_type;

   // configuration
   logic [TRIP_W-1:0] lift_ff [3];
   logic [TRIP_W-1:0] mount_ff;
   logic [TRIP_W-1:0] col0_ff;
   logic [TRIP_W-1:0] col1_ff;
   logic [TRIP_W-1:0] shift_ff;
   logic [63:0]       intr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lift_ff[0] <= '0;
         lift_ff[1] <= '0;
         lift_ff[2] <= '0;
         mount_ff   <= '0;
         col0_ff    <= '0;
         col1_ff    <= '0;
         shift_ff   <= '0;
         intr_ff    <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_LIFT_X:     lift_ff[0] <= csr_wdata[TRIP_W-1:0];
            REG_LIFT_Y:     lift_ff[1] <= csr_wdata[TRIP_W-1:0];
            REG_LIFT_Z:     lift_ff[2] <= csr_wdata[TRIP_W-1:0];
            REG_MOUNT:      mount_ff   <= csr_wdata[TRIP_W-1:0];
            REG_COL0:       col0_ff    <= csr_wdata[TRIP_W-1:0];
            REG_COL1:       col1_ff    <= csr_wdata[TRIP_W-1:0];
            REG_SHIFT:      shift_ff   <= csr_wdata[TRIP_W-1:0];
            REG_INTRINSICS: intr_ff    <= csr_wdata;
         endcase
      end
   end

   logic adv;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // valid bits
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, s6_v_ff, s7_v_ff;
   logic g1_v_ff, g2_v_ff, g3_v_ff, g4_v_ff, g5_v_ff;
   logic gd_v, pd_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         s4_v_ff      <= 1'b0;
         s5_v_ff      <= 1'b0;
         s6_v_ff      <= 1'b0;
         s7_v_ff      <= 1'b0;
         g1_v_ff      <= 1'b0;
         g2_v_ff      <= 1'b0;
         g3_v_ff      <= 1'b0;
         g4_v_ff      <= 1'b0;
         g5_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff      <= req_valid;
         s2_v_ff      <= s1_v_ff;
         s3_v_ff      <= s2_v_ff;
         s4_v_ff      <= s3_v_ff;
         s5_v_ff      <= s4_v_ff;
         s6_v_ff      <= s5_v_ff;
         s7_v_ff      <= s6_v_ff;
         g1_v_ff      <= gd_v;
         g2_v_ff      <= g1_v_ff;
         g3_v_ff      <= g2_v_ff;
         g4_v_ff      <= g3_v_ff;
         g5_v_ff      <= g4_v_ff;
         rsp_valid_ff <= pd_v;
      end
   end

   // s1: lift products
   logic signed [PROD_W-1:0] s1_pa_ff [3];
   logic signed [PROD_W-1:0] s1_pb_ff [3];
   logic signed [PIXEL_BITS:0] px_s, py_s;

   assign px_s = signed'({1'b0, req_pixel_x});
   assign py_s = signed'({1'b0, req_pixel_y});

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            s1_pa_ff[j] <= field21(lift_ff[j], 2'd0) * px_s;
            s1_pb_ff[j] <= field21(lift_ff[j], 2'd1) * py_s;
         end
      end
   end

   // s2: ray
   logic signed [RAY_W-1:0] s2_r_ff [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            s2_r_ff[j] <= RAY_W'(s1_pa_ff[j]) + RAY_W'(s1_pb_ff[j])
                          + RAY_W'(field21(lift_ff[j], 2'd2));
         end
      end
   end

   // s3: ground numerators, ray magnitudes
   logic signed [NUMS_W-1:0] s3_num_ff [2];
   logic [RAY_W-1:0]         s3_mag_ff [3];
   logic                     s3_rzneg_ff;
   logic signed [COEF_W-1:0] tz;

   assign tz = field21(mount_ff, 2'd2);

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 2; j++) begin
            s3_num_ff[j] <= tz * s2_r_ff[j];
         end
         for (int j = 0; j < 3; j++) begin
            s3_mag_ff[j] <= s2_r_ff[j][RAY_W-1] ? RAY_W'(-s2_r_ff[j]) : RAY_W'(s2_r_ff[j]);
         end
         s3_rzneg_ff <= s2_r_ff[2][RAY_W-1];
      end
   end

   // s4: normalizing shift
   gdiv_type         s4_gd_ff, s4_gd_in;
   logic [RAY_W-1:0] s4_mag_ff [3];
   logic [SH_W-1:0]  s4_sh_ff, s4_sh_in;
   logic             s4_rzneg_ff;
   logic [RAY_W-1:0] mag_or;

   assign mag_or = s3_mag_ff[0] | s3_mag_ff[1] | s3_mag_ff[2];

   always_comb begin
      s4_sh_in = '0;
      for (int k = NORM_W; k < RAY_W; k++) begin
         if (mag_or[k]) s4_sh_in = SH_W'(k - NORM_W + 1);
      end
      s4_gd_in.num0 = s3_num_ff[0][NUMS_W-1] ? NUMG_W'(-s3_num_ff[0]) : NUMG_W'(s3_num_ff[0]);
      s4_gd_in.num1 = s3_num_ff[1][NUMS_W-1] ? NUMG_W'(-s3_num_ff[1]) : NUMG_W'(s3_num_ff[1]);
      s4_gd_in.den  = s3_mag_ff[2];
      s4_gd_in.sgn0 = s3_num_ff[0][NUMS_W-1] ^ s3_rzneg_ff;
      s4_gd_in.sgn1 = s3_num_ff[1][NUMS_W-1] ^ s3_rzneg_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_gd_ff    <= s4_gd_in;
         s4_sh_ff    <= s4_sh_in;
         s4_rzneg_ff <= s3_rzneg_ff;
         for (int j = 0; j < 3; j++) s4_mag_ff[j] <= s3_mag_ff[j];
      end
   end

   // s5..s7: horizon test
   gdiv_type          s5_gd_ff, s6_gd_ff, s7_gd_ff;
   logic [NORM_W-1:0] s5_a_ff [3];
   logic [SQ_W-1:0]   s6_sq_ff [3];
   logic [SQ_W:0]     s7_sum_ff;
   logic [LIM_W-1:0]  s7_lim_ff;
   logic              s5_rzneg_ff, s6_rzneg_ff, s7_rzneg_ff;
   logic              rej;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            s5_a_ff[j]  <= NORM_W'(s4_mag_ff[j] >> s4_sh_ff);
            s6_sq_ff[j] <= SQ_W'(s5_a_ff[j]) * SQ_W'(s5_a_ff[j]);
         end
         s7_sum_ff   <= (SQ_W + 1)'(s6_sq_ff[0]) + (SQ_W + 1)'(s6_sq_ff[1]);
         s7_lim_ff   <= LIM_W'(s6_sq_ff[2]) * LIM_W'(HORIZON_RATIO);
         s5_gd_ff    <= s4_gd_ff;
         s6_gd_ff    <= s5_gd_ff;
         s7_gd_ff    <= s6_gd_ff;
         s5_rzneg_ff <= s4_rzneg_ff;
         s6_rzneg_ff <= s5_rzneg_ff;
         s7_rzneg_ff <= s6_rzneg_ff;
      end
   end

   assign rej = !s7_rzneg_ff || (LIM_W'(s7_sum_ff) > s7_lim_ff);

   // ground intersection divide
   logic [GQ_W-1:0] gd_q0, gd_q1;
   logic            gd_ovf0, gd_ovf1;
   logic [2:0]      gd_side;

   gppr_div #(
      .NUM_W  (NUMG_W),
      .DEN_W  (RAY_W),
      .QUO_W  (GQ_W),
      .SIDE_W (3)
   ) u_ground_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s7_v_ff),
      .in_num0   (s7_gd_ff.num0),
      .in_num1   (s7_gd_ff.num1),
      .in_den    (s7_gd_ff.den),
      .in_side   ({rej, s7_gd_ff.sgn1, s7_gd_ff.sgn0}),
      .out_valid (gd_v),
      .out_quo0  (gd_q0),
      .out_quo1  (gd_q1),
      .out_ovf0  (gd_ovf0),
      .out_ovf1  (gd_ovf1),
      .out_side  (gd_side)
   );

   // g1: ground point
   logic signed [GROUND_W-1:0] g1_g_ff [2];
   logic signed [GROUND_W-1:0] gq_s [2];
   logic                       g1_rej_ff;

   always_comb begin
      gq_s[0] = signed'(GROUND_W'(gd_q0));
      gq_s[1] = signed'(GROUND_W'(gd_q1));
      if (gd_side[0]) gq_s[0] = -gq_s[0];
      if (gd_side[1]) gq_s[1] = -gq_s[1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g1_g_ff[0] <= GROUND_W'(field21(mount_ff, 2'd0)) - gq_s[0];
         g1_g_ff[1] <= GROUND_W'(field21(mount_ff, 2'd1)) - gq_s[1];
         g1_rej_ff  <= gd_side[2];
      end
   end

   // g2, g3: motion into the earlier camera frame
   logic signed [GPROD_W-1:0] g2_pa_ff [3];
   logic signed [GPROD_W-1:0] g2_pb_ff [3];
   logic signed [CAM_W-1:0]   g3_cam_ff [3];
   logic                      g2_rej_ff, g3_rej_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            g2_pa_ff[k]  <= field21(col0_ff, 2'(k)) * g1_g_ff[0];
            g2_pb_ff[k]  <= field21(col1_ff, 2'(k)) * g1_g_ff[1];
            g3_cam_ff[k] <= CAM_W'(g2_pa_ff[k]) + CAM_W'(g2_pb_ff[k])
                            + (CAM_W'(field21(shift_ff, 2'(k))) <<< 18);
         end
         g2_rej_ff <= g1_rej_ff;
         g3_rej_ff <= g2_rej_ff;
      end
   end

   // g4: depth test, Q.18 magnitudes
   logic signed [CAM_W-Q18_SH-1:0] x18 [2];
   logic [MAG18_W-1:0]             g4_mag_ff [2];
   logic                           g4_sgn_ff [2];
   logic [MAG18_W-1:0]             g4_z_ff;
   status_type                     g4_pre_ff;
   logic                           behind;

   assign x18[0] = signed'(g3_cam_ff[0][CAM_W-1:Q18_SH]);
   assign x18[1] = signed'(g3_cam_ff[1][CAM_W-1:Q18_SH]);
   assign behind = g3_cam_ff[2] < CAM_W'(DEPTH_MIN_Q32);

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 2; l++) begin
            g4_mag_ff[l] <= x18[l][CAM_W-Q18_SH-1] ? MAG18_W'(-x18[l]) : MAG18_W'(x18[l]);
            g4_sgn_ff[l] <= x18[l][CAM_W-Q18_SH-1];
         end
         g4_z_ff   <= g3_cam_ff[2][Q18_SH +: MAG18_W];
         g4_pre_ff <= g3_rej_ff ? STATUS_HORIZON : (behind ? STATUS_BEHIND : STATUS_OK);
      end
   end

   // g5: projection numerators
   logic [NUMP_W-1:0]  g5_num_ff [2];
   logic [MAG18_W-1:0] g5_z_ff;
   logic               g5_sgn_ff [2];
   status_type         g5_pre_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         g5_num_ff[0] <= (NUMP_W'(intr_ff[15:0]) * NUMP_W'(g4_mag_ff[0])) << SCALE_SH;
         g5_num_ff[1] <= (NUMP_W'(intr_ff[31:16]) * NUMP_W'(g4_mag_ff[1])) << SCALE_SH;
         g5_z_ff      <= g4_z_ff;
         g5_sgn_ff[0] <= g4_sgn_ff[0];
         g5_sgn_ff[1] <= g4_sgn_ff[1];
         g5_pre_ff    <= g4_pre_ff;
      end
   end

   // perspective divide
   logic [PQ_W-1:0] pd_q [2];
   logic            pd_ovf [2];
   logic [3:0]      pd_side;

   gppr_div #(
      .NUM_W  (NUMP_W),
      .DEN_W  (MAG18_W),
      .QUO_W  (PQ_W),
      .SIDE_W (4)
   ) u_proj_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (g5_v_ff),
      .in_num0   (g5_num_ff[0]),
      .in_num1   (g5_num_ff[1]),
      .in_den    (g5_z_ff),
      .in_side   ({g5_pre_ff, g5_sgn_ff[1], g5_sgn_ff[0]}),
      .out_valid (pd_v),
      .out_quo0  (pd_q[0]),
      .out_quo1  (pd_q[1]),
      .out_ovf0  (pd_ovf[0]),
      .out_ovf1  (pd_ovf[1]),
      .out_side  (pd_side)
   );

   // output: center offset, clamp
   logic signed [SUM_W-1:0] qs [2];
   logic signed [SUM_W-1:0] psum [2];
   logic [15:0]             cen [2];
   logic                    hi [2];
   logic                    lo [2];
   logic signed [OUT_W-1:0] clamped [2];
   status_type              pre;
   status_type              rsp_status_ff, rsp_status_in;
   logic signed [OUT_W-1:0] rsp_proj_x_ff, rsp_proj_y_ff;

   assign cen[0] = intr_ff[47:32];
   assign cen[1] = intr_ff[63:48];
   assign pre    = status_type'(pd_side[3:2]);

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         qs[l] = signed'(SUM_W'(pd_q[l]));
         if (pd_side[l]) qs[l] = -qs[l];
         psum[l] = qs[l] + signed'(SUM_W'(cen[l]) << SCALE_SH);
         hi[l] = pd_ovf[l] ? !pd_side[l] : (psum[l] > SUM_W'(OUT_MAX));
         lo[l] = pd_ovf[l] ? pd_side[l] : (psum[l] < SUM_W'(OUT_MIN));
         clamped[l] = hi[l] ? OUT_W'(OUT_MAX) : (lo[l] ? OUT_W'(OUT_MIN) : OUT_W'(psum[l]));
      end
      if (pre != STATUS_OK) begin
         rsp_status_in = pre;
      end else if (hi[0] || lo[0] || hi[1] || lo[1]) begin
         rsp_status_in = STATUS_SAT;
      end else begin
         rsp_status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_status_ff <= rsp_status_in;
         rsp_proj_x_ff <= (pre != STATUS_OK) ? '0 : clamped[0];
         rsp_proj_y_ff <= (pre != STATUS_OK) ? '0 : clamped[1];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_proj_x = rsp_proj_x_ff;
   assign rsp_proj_y = rsp_proj_y_ff;

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == STATUS_HORIZON || rsp_status_ff == STATUS_BEHIND)
      |-> rsp_proj_x_ff == '0 && rsp_proj_y_ff == '0)
      else $error("rejected transaction carries nonzero coordinates");

   a_sat_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_SAT
      |-> rsp_proj_x_ff == OUT_W'(OUT_MAX) || rsp_proj_x_ff == OUT_W'(OUT_MIN)
          || rsp_proj_y_ff == OUT_W'(OUT_MAX) || rsp_proj_y_ff == OUT_W'(OUT_MIN))
      else $error("saturated status without a clamped coordinate");

   a_ground_fits: assert property (@(posedge clock) disable iff (reset)
      gd_v && !gd_side[2] |-> !gd_ovf0 && !gd_ovf1)
      else $error("ground intersection quotient out of range");

endmodule
